// File: rtl/core/jsud_pkg.sv
package jsud_pkg;

    // field widths
    localparam int unsigned ByteW   = 8;
    localparam int unsigned CpW     = 21;
    localparam int unsigned StatusW = 2;
    localparam int unsigned HexW    = 16;
    localparam int unsigned HighW   = 10;
    localparam int unsigned LeftW   = 3;
    localparam int unsigned ModeW   = 2;

    // width mode codes, the spare code acts as four-byte units
    localparam logic [ModeW-1:0] MODE_ONE      = 2'd0;
    localparam logic [ModeW-1:0] MODE_TWO      = 2'd1;
    localparam logic [ModeW-1:0] MODE_FOUR     = 2'd2;
    localparam logic [ModeW-1:0] MODE_FOUR_ALT = 2'd3;

    // result status codes
    localparam logic [StatusW-1:0] ST_OK        = 2'd0;
    localparam logic [StatusW-1:0] ST_BAD_ESC   = 2'd1;
    localparam logic [StatusW-1:0] ST_BAD_LEAD  = 2'd2;
    localparam logic [StatusW-1:0] ST_TRUNCATED = 2'd3;

    // characters of interest
    localparam logic [ByteW-1:0] CH_BSLASH = 8'h5C;
    localparam logic [ByteW-1:0] CH_QUOTE  = 8'h22;
    localparam logic [ByteW-1:0] CH_SLASH  = 8'h2F;
    localparam logic [ByteW-1:0] CH_B      = 8'h62;
    localparam logic [ByteW-1:0] CH_F      = 8'h66;
    localparam logic [ByteW-1:0] CH_N      = 8'h6E;
    localparam logic [ByteW-1:0] CH_R      = 8'h72;
    localparam logic [ByteW-1:0] CH_T      = 8'h74;
    localparam logic [ByteW-1:0] CH_U      = 8'h75;

    // surrogate constants
    localparam logic [HexW-1:0] HIGH_SURR_LO = 16'hD800;
    localparam logic [HexW-1:0] HIGH_SURR_HI = 16'hDBFF;
    localparam logic [CpW-1:0]  SUPP_BASE    = 21'h10000;

    typedef enum logic [2:0] {
        PH_NORMAL  = 3'd0,
        PH_ESC     = 3'd1,
        PH_HEX     = 3'd2,
        PH_HEX_BAD = 3'd3,
        PH_UTF8    = 3'd4,
        PH_SKIP    = 3'd5,
        PH_LOW     = 3'd6,
        PH_LOW_BAD = 3'd7
    } phase_t;

    // one result item
    typedef struct packed {
        logic [CpW-1:0]     code_point;
        logic [StatusW-1:0] status;
        logic               final_res;
    } res_t;

    // one input item
    typedef struct packed {
        logic [ByteW-1:0] byte_in;
        logic             end_of_string;
    } item_t;

    // hex digit value, bit 4 set when the digit is valid
    function automatic logic [4:0] hex_digit(input logic [ByteW-1:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39)
            r = {1'b1, b[3:0]};
        else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66))
            r = {1'b1, b[3:0] + 4'd9};
        return r;
    endfunction

endpackage

// File: rtl/core/jsud_in_reg.sv
module jsud_in_reg
    import jsud_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  s_tvalid,
    output logic  s_tready,
    input  item_t s_item,
    input  logic  take,
    output logic  item_valid,
    output item_t item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // free slot or the held item leaves this cycle
    assign s_tready = !valid_reg || take;

    always_comb
    begin
        if (s_tvalid && s_tready)
            valid_next = 1'b1;
        else if (take)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            item_reg <= s_item;
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// File: rtl/core/jsud_decode.sv
module jsud_decode
    import jsud_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [ModeW-1:0] width_mode,
    input  logic             item_valid,
    input  item_t            item,
    input  logic             res_ready,
    output logic             take,
    output logic             res_valid,
    output res_t             res
);

    phase_t           phase_reg, phase_next;
    logic [CpW-1:0]   char_reg, char_next;
    logic [HexW-1:0]  hex_reg, hex_next;
    logic [HighW-1:0] high_reg, high_next;
    logic [LeftW-1:0] left_reg, left_next;
    logic             failed_reg, failed_next;

    logic [ModeW-1:0]   mode;
    logic [ByteW-1:0]   b;
    logic               eos;
    logic               emit;
    logic               has_res;
    logic [CpW-1:0]     cp;
    logic [StatusW-1:0] st;
    logic [4:0]         dig;
    logic [HexW-1:0]    hex_sh;
    logic [LeftW-1:0]   left_dec;
    logic [HexW-1:0]    v;
    logic [CpW-1:0]     char_sh;

    assign mode     = (width_mode == MODE_FOUR_ALT) ? MODE_FOUR : width_mode;
    assign b        = item.byte_in;
    assign eos      = item.end_of_string;
    assign dig      = hex_digit(b);
    assign hex_sh   = {hex_reg[HexW-5:0], dig[3:0] & {4{dig[4]}}};
    assign left_dec = left_reg - 3'd1;
    assign char_sh  = {char_reg[CpW-7:0], b[5:0]};

    // one step of the decoder
    always_comb
    begin
        phase_next  = phase_reg;
        char_next   = char_reg;
        hex_next    = hex_reg;
        high_next   = high_reg;
        left_next   = left_reg;
        failed_next = failed_reg;
        emit        = 1'b0;
        cp          = '0;
        st          = ST_OK;
        v           = '0;

        if (failed_reg)
        begin
            if (eos)
            begin
                phase_next  = PH_NORMAL;
                char_next   = '0;
                hex_next    = '0;
                high_next   = '0;
                left_next   = '0;
                failed_next = 1'b0;
            end
        end
        else
        begin
            case (phase_reg)
                PH_NORMAL:
                begin
                    if (b == CH_BSLASH)
                        phase_next = PH_ESC;
                    else if (!b[7])
                    begin
                        emit = 1'b1;
                        cp   = {13'd0, b};
                    end
                    else if (!b[6])
                        st = ST_BAD_LEAD;
                    else if (!b[5])
                    begin
                        char_next  = {16'd0, b[4:0]};
                        left_next  = 3'd1;
                        phase_next = PH_UTF8;
                    end
                    else if (!b[4])
                    begin
                        if (mode == MODE_ONE)
                            st = ST_BAD_LEAD;
                        else
                        begin
                            char_next  = {17'd0, b[3:0]};
                            left_next  = 3'd2;
                            phase_next = PH_UTF8;
                        end
                    end
                    else
                    begin
                        if (mode != MODE_FOUR)
                            st = ST_BAD_LEAD;
                        else
                        begin
                            char_next  = {18'd0, b[2:0]};
                            left_next  = 3'd3;
                            phase_next = PH_UTF8;
                        end
                    end
                end
                PH_ESC:
                begin
                    phase_next = PH_NORMAL;
                    emit       = 1'b1;
                    case (b)
                        CH_B:      cp = 21'h08;
                        CH_F:      cp = 21'h0C;
                        CH_N:      cp = 21'h0A;
                        CH_R:      cp = 21'h0D;
                        CH_T:      cp = 21'h09;
                        CH_QUOTE,
                        CH_BSLASH,
                        CH_SLASH:  cp = {13'd0, b};
                        CH_U:
                        begin
                            emit       = 1'b0;
                            phase_next = PH_HEX;
                            hex_next   = '0;
                            left_next  = 3'd4;
                        end
                        default:
                        begin
                            emit = 1'b0;
                            st   = ST_BAD_ESC;
                        end
                    endcase
                end
                PH_HEX, PH_HEX_BAD:
                begin
                    hex_next  = hex_sh;
                    left_next = left_dec;
                    if (!dig[4])
                        phase_next = PH_HEX_BAD;
                    if (left_dec == 3'd0)
                    begin
                        v = (phase_next == PH_HEX_BAD) ? '0 : hex_sh;
                        if (mode == MODE_FOUR && v >= HIGH_SURR_LO && v <= HIGH_SURR_HI)
                        begin
                            high_next  = v[HighW-1:0];
                            left_next  = 3'd2;
                            phase_next = PH_SKIP;
                        end
                        else
                        begin
                            emit       = 1'b1;
                            cp         = {5'd0, v};
                            phase_next = PH_NORMAL;
                        end
                    end
                end
                PH_UTF8:
                begin
                    char_next = char_sh;
                    left_next = left_dec;
                    if (left_dec == 3'd0)
                    begin
                        emit       = 1'b1;
                        cp         = char_sh;
                        phase_next = PH_NORMAL;
                    end
                end
                PH_SKIP:
                begin
                    left_next = left_dec;
                    if (left_dec == 3'd0)
                    begin
                        phase_next = PH_LOW;
                        hex_next   = '0;
                        left_next  = 3'd4;
                    end
                end
                PH_LOW, PH_LOW_BAD:
                begin
                    hex_next  = hex_sh;
                    left_next = left_dec;
                    if (!dig[4])
                        phase_next = PH_LOW_BAD;
                    if (left_dec == 3'd0)
                    begin
                        v          = (phase_next == PH_LOW_BAD) ? '0 : hex_sh;
                        emit       = 1'b1;
                        cp         = SUPP_BASE + {1'b0, high_reg, v[HighW-1:0]};
                        phase_next = PH_NORMAL;
                    end
                end
                default:
                begin
                    phase_next = PH_NORMAL;
                end
            endcase

            // string ends inside a sequence
            if (!emit && st == ST_OK && eos && phase_next != PH_NORMAL)
                st = ST_TRUNCATED;

            if (st != ST_OK)
            begin
                emit = 1'b0;
                cp   = '0;
                if (!eos)
                    failed_next = 1'b1;
            end

            if (eos)
            begin
                phase_next = PH_NORMAL;
                char_next  = '0;
                hex_next   = '0;
                high_next  = '0;
                left_next  = '0;
            end

            // truncate to the code unit width
            if (mode == MODE_ONE)
                cp = {13'd0, cp[7:0]};
            else if (mode == MODE_TWO)
                cp = {5'd0, cp[15:0]};
        end
    end

    assign has_res        = !failed_reg && (emit || st != ST_OK);
    assign take           = item_valid && (!has_res || res_ready);
    assign res_valid      = take && has_res;
    assign res.code_point = cp;
    assign res.status     = st;
    assign res.final_res  = eos;

    // decoder state, advanced once per transfer taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_NORMAL;
            char_reg   <= '0;
            hex_reg    <= '0;
            high_reg   <= '0;
            left_reg   <= '0;
            failed_reg <= 1'b0;
        end
        else if (take)
        begin
            phase_reg  <= phase_next;
            char_reg   <= char_next;
            hex_reg    <= hex_next;
            high_reg   <= high_next;
            left_reg   <= left_next;
            failed_reg <= failed_next;
        end
    end

endmodule

// File: rtl/core/jsud_out_reg.sv
module jsud_out_reg
    import jsud_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic res_valid,
    input  res_t res,
    output logic res_ready,
    output logic m_tvalid,
    input  logic m_tready,
    output res_t m_res
);

    logic valid_reg;
    logic valid_next;
    res_t res_reg;

    // slot free or drained this cycle
    assign res_ready = !valid_reg || m_tready;

    always_comb
    begin
        if (res_valid)
            valid_next = 1'b1;
        else if (m_tready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
            res_reg <= res;
    end

    assign m_tvalid = valid_reg;
    assign m_res    = res_reg;

endmodule

// File: rtl/core/json_string_unescape_decoder.sv
// channel  | ports                              | payload
// ---------+------------------------------------+--------------------------------------
// input    | s_tvalid s_tready s_tdata s_tlast  | byte_in [7:0]; end_of_string on tlast
// output   | m_tvalid m_tready m_tdata m_tlast  | code_point [20:0], status [22:21]
//          |                                    | ([23] zero); final_res on tlast
// config   | cfg_valid cfg_ready cfg_data       | width_mode [1:0]
//
// one byte per cycle sustained while results are taken; a byte passes input register,
// decode step and output register, from which its result is offered on the output
// reset clears the decoder to normal text and sets width_mode to four-byte units
// a full output register that is not taken stalls the input only when the next byte has a result
module json_string_unescape_decoder
    import jsud_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // byte_in
    input  logic        s_tlast,   // end_of_string
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // code_point, status, zero pad
    output logic        m_tlast,   // final_res
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_data   // width_mode
);

    logic [ModeW-1:0] mode_reg;
    item_t            s_item;
    item_t            item;
    logic             item_valid;
    logic             take;
    logic             res_valid;
    logic             res_ready;
    res_t             res;
    res_t             m_res;

    // width mode register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= MODE_FOUR;
        else if (cfg_valid && cfg_ready)
            mode_reg <= cfg_data;
    end

    assign s_item.byte_in       = s_tdata;
    assign s_item.end_of_string = s_tlast;

    jsud_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    jsud_decode u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .width_mode (mode_reg),
        .item_valid (item_valid),
        .item       (item),
        .res_ready  (res_ready),
        .take       (take),
        .res_valid  (res_valid),
        .res        (res)
    );

    jsud_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_res     (m_res)
    );

    assign m_tdata = {1'b0, m_res.status, m_res.code_point};
    assign m_tlast = m_res.final_res;

endmodule

// File: rtl/core/jsud_checker.sv
module jsud_checker
    import jsud_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tlast,
    input logic        cfg_ready
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // an error result carries no code point
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[22:21] != ST_OK |-> m_tdata[20:0] == 21'd0)
        else $error("error result with nonzero code point");

    // pad bit of the result stays zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !m_tdata[23])
        else $error("result pad bit set");

    // input back-pressure only behind a stalled output
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready && cfg_ready)
        else $error("input stalled without output stall");

endmodule

bind json_string_unescape_decoder jsud_checker u_jsud_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_ready (cfg_ready)
);

// File: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import jsud_pkg::*;

    localparam int unsigned CycleLimit = 200000;
    localparam int unsigned QuietWait  = 4;
    localparam int unsigned EndWait    = 10;
    localparam int unsigned PhaseBytes = 90;
    localparam int unsigned NumPhases  = 9;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // byte_in
    logic        s_tlast;   // end_of_string
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;   // code_point [20:0], status [22:21], zero pad
    logic        m_tlast;   // final_res
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_data;  // width_mode

    // decoder predictor and queue of expected characters
    class char_scoreboard;
        logic [1:0]  width_mode;
        phase_t      phase;
        logic [20:0] char_acc;
        logic [15:0] hex_acc;
        logic [9:0]  high_bits;
        logic [2:0]  left;
        bit          failed;
        res_t        expected_chars[$];
        int          mismatches;
        int          checked;
        int          status_seen[4];

        function new();
            width_mode = MODE_FOUR;
            clear();
            mismatches = 0;
            checked = 0;
            foreach (status_seen[i])
                status_seen[i] = 0;
        endfunction

        function void clear();
            phase = PH_NORMAL;
            char_acc = '0;
            hex_acc = '0;
            high_bits = '0;
            left = '0;
            failed = 1'b0;
        endfunction

        // value of a hex digit, -1 when the byte is not one
        function int digit_value(logic [7:0] b);
            if (b >= 8'h30 && b <= 8'h39)
                return int'(b - 8'h30);
            if (b >= 8'h41 && b <= 8'h46)
                return int'(b - 8'h41) + 10;
            if (b >= 8'h61 && b <= 8'h66)
                return int'(b - 8'h61) + 10;
            return -1;
        endfunction

        // shift one digit in, true once the fourth has come
        function bit shift_digit(logic [7:0] b, phase_t bad_phase);
            int d;
            d = digit_value(b);
            if (d < 0)
            begin
                phase = bad_phase;
                d = 0;
            end
            hex_acc = {hex_acc[11:0], d[3:0]};
            left = left - 3'd1;
            return left == 3'd0;
        endfunction

        // predict the result of one accepted byte
        function void take_byte(logic [7:0] b, bit eos);
            bit          one;
            bit          four;
            bit          emit;
            logic [20:0] cp;
            logic [1:0]  st;
            logic [15:0] v;
            res_t        r;
            one = (width_mode == MODE_ONE);
            four = width_mode[1];
            emit = 1'b0;
            cp = '0;
            st = ST_OK;
            // dropping bytes after an error
            if (failed)
            begin
                if (eos)
                    clear();
                return;
            end
            case (phase)
                PH_NORMAL:
                begin
                    if (b == CH_BSLASH)
                        phase = PH_ESC;
                    else if (!b[7])
                    begin
                        emit = 1'b1;
                        cp = {13'd0, b};
                    end
                    else if (!b[6])
                        st = ST_BAD_LEAD;
                    else if (!b[5])
                    begin
                        char_acc = {16'd0, b[4:0]};
                        left = 3'd1;
                        phase = PH_UTF8;
                    end
                    else if (!b[4])
                    begin
                        if (one)
                            st = ST_BAD_LEAD;
                        else
                        begin
                            char_acc = {17'd0, b[3:0]};
                            left = 3'd2;
                            phase = PH_UTF8;
                        end
                    end
                    else
                    begin
                        if (!four)
                            st = ST_BAD_LEAD;
                        else
                        begin
                            char_acc = {18'd0, b[2:0]};
                            left = 3'd3;
                            phase = PH_UTF8;
                        end
                    end
                end
                PH_ESC:
                begin
                    phase = PH_NORMAL;
                    emit = 1'b1;
                    case (b)
                        CH_B: cp = 21'h08;
                        CH_F: cp = 21'h0C;
                        CH_N: cp = 21'h0A;
                        CH_R: cp = 21'h0D;
                        CH_T: cp = 21'h09;
                        CH_QUOTE, CH_BSLASH, CH_SLASH: cp = {13'd0, b};
                        CH_U:
                        begin
                            emit = 1'b0;
                            phase = PH_HEX;
                            hex_acc = '0;
                            left = 3'd4;
                        end
                        default:
                        begin
                            emit = 1'b0;
                            st = ST_BAD_ESC;
                        end
                    endcase
                end
                PH_HEX, PH_HEX_BAD:
                begin
                    if (shift_digit(b, PH_HEX_BAD))
                    begin
                        v = (phase == PH_HEX_BAD) ? 16'd0 : hex_acc;
                        if (four && v >= HIGH_SURR_LO && v <= HIGH_SURR_HI)
                        begin
                            high_bits = v[9:0];
                            left = 3'd2;
                            phase = PH_SKIP;
                        end
                        else
                        begin
                            emit = 1'b1;
                            cp = {5'd0, v};
                            phase = PH_NORMAL;
                        end
                    end
                end
                PH_UTF8:
                begin
                    char_acc = {char_acc[14:0], b[5:0]};
                    left = left - 3'd1;
                    if (left == 3'd0)
                    begin
                        emit = 1'b1;
                        cp = char_acc;
                        phase = PH_NORMAL;
                    end
                end
                PH_SKIP:
                begin
                    // the two bytes between the halves are not looked at
                    left = left - 3'd1;
                    if (left == 3'd0)
                    begin
                        phase = PH_LOW;
                        hex_acc = '0;
                        left = 3'd4;
                    end
                end
                default:
                begin
                    if (shift_digit(b, PH_LOW_BAD))
                    begin
                        v = (phase == PH_LOW_BAD) ? 16'd0 : hex_acc;
                        emit = 1'b1;
                        cp = SUPP_BASE + {1'b0, high_bits, v[9:0]};
                        phase = PH_NORMAL;
                    end
                end
            endcase

            // final byte inside an unfinished sequence
            if (!emit && st == ST_OK && eos && phase != PH_NORMAL)
                st = ST_TRUNCATED;
            if (st != ST_OK)
            begin
                r.code_point = '0;
                r.status = st;
                r.final_res = eos;
                expected_chars.push_back(r);
                if (eos)
                    clear();
                else
                    failed = 1'b1;
                return;
            end
            if (eos)
                clear();
            if (!emit)
                return;
            // truncate to the code unit width
            if (one)
                cp = {13'd0, cp[7:0]};
            else if (width_mode == MODE_TWO)
                cp = {5'd0, cp[15:0]};
            r.code_point = cp;
            r.status = ST_OK;
            r.final_res = eos;
            expected_chars.push_back(r);
        endfunction

        task report(string msg);
            mismatches++;
            $display("mismatch at %0t: %s", $realtime, msg);
        endtask

        // compare one result transfer with the oldest expectation
        task check_char(logic [20:0] cp, logic [1:0] st, logic fin);
            res_t e;
            if (expected_chars.size() == 0)
            begin
                report($sformatf("result with nothing pending: cp %h status %0d last %0b",
                                 cp, st, fin));
                return;
            end
            e = expected_chars.pop_front();
            checked++;
            status_seen[e.status]++;
            if (cp !== e.code_point)
                report($sformatf("code_point %h, predicted %h", cp, e.code_point));
            if (st !== e.status)
                report($sformatf("status %0d, predicted %0d", st, e.status));
            if (fin !== e.final_res)
                report($sformatf("final flag %0b, predicted %0b", fin, e.final_res));
        endtask
    endclass

    char_scoreboard board = new();

    item_t      byte_plan[$];
    logic [7:0] str_bytes[$];
    bit         idle_on = 1'b1;
    int         idle_odds = 3;
    int         stall_left = 0;
    int         bytes_sent = 0;
    int         strings_sent = 0;
    int         cycle_count = 0;

    json_string_unescape_decoder i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // output side: check each transfer, stall in bursts
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            board.check_char(m_tdata[20:0], m_tdata[22:21], m_tlast);
        if (stall_left > 0)
        begin
            m_tready <= 1'b0;
            stall_left--;
        end
        else if (idle_on && $urandom_range(0, idle_odds) == 0)
        begin
            m_tready <= 1'b0;
            stall_left = int'($urandom_range(0, 3));
        end
        else
            m_tready <= 1'b1;
    end

    // run limit
    initial
    begin
        while (cycle_count < CycleLimit)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("testbench: FAIL");
        $finish;
    end

    function automatic logic [7:0] hex_char(logic [3:0] n);
        if (n < 4'd10)
            return 8'h30 + {4'd0, n};
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + {4'd0, n} - 8'd10;
    endfunction

    function automatic logic [7:0] non_hex_char();
        case ($urandom_range(0, 3))
            0: return 8'h67 + 8'($urandom_range(0, 19));
            1: return 8'h3A + 8'($urandom_range(0, 6));
            2: return 8'h80 | 8'($urandom_range(0, 127));
            default: return 8'($urandom_range(0, 8'h2F));
        endcase
    endfunction

    function automatic logic [7:0] cont_byte();
        if ($urandom_range(0, 7) == 0)
            return 8'($urandom_range(0, 255));
        return 8'h80 | 8'($urandom_range(0, 63));
    endfunction

    // \uXXXX, one digit spoiled when bad_pos is 0..3
    function automatic void add_uhex(logic [15:0] v, int bad_pos);
        str_bytes.push_back(CH_BSLASH);
        str_bytes.push_back(CH_U);
        for (int i = 0; i < 4; i++)
            str_bytes.push_back(i == bad_pos ? non_hex_char() : hex_char(v[15 - 4 * i -: 4]));
    endfunction

    // one character token, mostly well formed
    function automatic void add_token(logic [1:0] m);
        int          k;
        logic [15:0] v;
        logic [7:0]  b;
        logic [7:0]  esc_set[8];
        esc_set = '{CH_B, CH_F, CH_N, CH_R, CH_T, CH_QUOTE, CH_BSLASH, CH_SLASH};
        k = int'($urandom_range(0, 99));
        // four-byte leads fail in both narrow modes and three-byte leads in mode one, keep most strings alive there
        if (!m[1] && k >= 70 && k < 84 && $urandom_range(0, 3) != 0)
            k = 0;
        if (k < 30)
        begin
            b = 8'($urandom_range(0, 127));
            str_bytes.push_back(b == CH_BSLASH ? 8'h41 : b);
        end
        else if (k < 42)
        begin
            str_bytes.push_back(CH_BSLASH);
            str_bytes.push_back(esc_set[3'($urandom_range(0, 7))]);
        end
        else if (k < 52)
        begin
            v = 16'($urandom_range(0, 16'hFFFF));
            add_uhex(v, -1);
            if (m[1] && v >= HIGH_SURR_LO && v <= HIGH_SURR_HI)
                add_uhex(16'hDC00 | 16'($urandom_range(0, 1023)), -1);
        end
        else if (k < 60)
        begin
            add_uhex(HIGH_SURR_LO | 16'($urandom_range(0, 1023)), -1);
            add_uhex(16'hDC00 | 16'($urandom_range(0, 1023)), -1);
        end
        else if (k < 70)
        begin
            str_bytes.push_back(8'hC0 | 8'($urandom_range(0, 31)));
            str_bytes.push_back(cont_byte());
        end
        else if (k < 78)
        begin
            str_bytes.push_back(8'hE0 | 8'($urandom_range(0, 15)));
            repeat (2) str_bytes.push_back(cont_byte());
        end
        else if (k < 84)
        begin
            // some leads from the F8..FF range
            if ($urandom_range(0, 3) == 0)
                str_bytes.push_back(8'hF8 | 8'($urandom_range(0, 7)));
            else
                str_bytes.push_back(8'hF0 | 8'($urandom_range(0, 7)));
            repeat (3) str_bytes.push_back(cont_byte());
        end
        else if (k < 92)
            str_bytes.push_back(8'($urandom_range(0, 255)));
        else if (k < 96)
        begin
            str_bytes.push_back(CH_BSLASH);
            str_bytes.push_back(8'($urandom_range(0, 255)));
        end
        else
            add_uhex(16'($urandom_range(0, 16'hFFFF)), int'($urandom_range(0, 3)));
    endfunction

    // move the collected bytes to the plan, flagging the last one
    function automatic void plan_string();
        item_t it;
        foreach (str_bytes[i])
        begin
            it.byte_in = str_bytes[i];
            it.end_of_string = (i == str_bytes.size() - 1);
            byte_plan.push_back(it);
        end
        str_bytes.delete();
        strings_sent++;
    endfunction

    // random string, now and then cut short, which can end it inside a sequence
    function automatic void build_string(logic [1:0] m);
        int cut;
        str_bytes.delete();
        repeat ($urandom_range(1, 8)) add_token(m);
        if ($urandom_range(0, 5) == 0 && str_bytes.size() > 1)
        begin
            cut = int'($urandom_range(1, str_bytes.size() > 3 ? 3 : str_bytes.size() - 1));
            repeat (cut) void'(str_bytes.pop_back());
        end
        plan_string();
    endfunction

    // input side: one transfer per planned byte, gaps in bursts
    task automatic send_plan();
        item_t it;
        while (byte_plan.size() > 0)
        begin
            it = byte_plan.pop_front();
            if (idle_on && $urandom_range(0, idle_odds) == 0)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata <= it.byte_in;
            s_tlast <= it.end_of_string;
            do @(posedge clk); while (!s_tready);
            board.take_byte(it.byte_in, it.end_of_string);
            bytes_sent++;
        end
        s_tvalid <= 1'b0;
    endtask

    task automatic write_mode(logic [1:0] m);
        cfg_valid <= 1'b1;
        cfg_data <= m;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        board.width_mode = m;
    endtask

    // drain pending results, then let bytes with no result clear the pipe
    task automatic wait_quiet(int extra);
        while (board.expected_chars.size() > 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    // main sequence
    initial
    begin
        logic [1:0] mode_seq[NumPhases];
        mode_seq = '{MODE_ONE, MODE_TWO, MODE_FOUR_ALT, MODE_FOUR, MODE_TWO, MODE_ONE,
                     MODE_FOUR, MODE_FOUR_ALT, MODE_FOUR};
        rst_n <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tlast <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: ascii extremes, escape, 3- and 4-byte utf-8, surrogate pair
        str_bytes = '{8'h00, 8'h7F, CH_BSLASH, CH_SLASH, 8'hE2, 8'h82, 8'hAC,
                      8'hF0, 8'h9F, 8'h98, 8'h80};
        add_uhex(16'hD83D, -1);
        add_uhex(16'hDE00, -1);
        plan_string();
        // continuation byte as lead on the final byte
        str_bytes.push_back(8'h80);
        plan_string();
        // string ending right after a backslash
        str_bytes.push_back(CH_BSLASH);
        plan_string();
        send_plan();
        wait_quiet(QuietWait);

        // random phases, one width mode each
        for (int p = 0; p < NumPhases; p++)
        begin
            if (p == NumPhases - 1)
                idle_on = 1'b0;
            else
                idle_odds = (p % 3 == 0) ? 1 : ((p % 3 == 1) ? 3 : 8);
            write_mode(mode_seq[p]);
            while (byte_plan.size() < PhaseBytes)
                build_string(mode_seq[p]);
            send_plan();
            wait_quiet(QuietWait);
        end
        wait_quiet(EndWait);

        $display("summary: %0d bytes in %0d strings, width modes 0 to 3, %0d results checked",
                 bytes_sent, strings_sent, board.checked);
        $display("summary: errors seen - bad escape %0d, bad lead %0d, truncated %0d",
                 board.status_seen[ST_BAD_ESC], board.status_seen[ST_BAD_LEAD],
                 board.status_seen[ST_TRUNCATED]);
        if (board.mismatches == 0 && board.expected_chars.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
